@@ sv/bcmp_pkg.sv @@
// Package: request types, result kinds, command codes and defaults for the mailbox parser.
`timescale 1ns / 1ps
`default_nettype none
package bcmp_pkg;

    localparam int BCMP_SLOT_COUNT     = 10;
    localparam int BCMP_MESSAGE_LENGTH = 13;
    localparam int BCMP_DATE_LENGTH    = 5;

    localparam int DATE_VALUE_BYTES = 5;
    localparam int SLOT_STRIDE_SHIFT = 4;

    localparam logic [7:0] CMD_BASE     = 8'd200;
    localparam logic [7:0] CMD_PIN_LOW  = 8'hF0;
    localparam logic [7:0] CMD_PIN_HIGH = 8'hFF;
    localparam logic [7:0] CMD_TEMP     = 8'hEE;
    localparam logic [7:0] CH_COMMIT    = 8'h21;
    localparam logic [7:0] CH_DATE      = 8'h5F;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [2:0] {
        KIND_MEM_WRITE = 3'd0,
        KIND_REJECT    = 3'd1,
        KIND_PIN       = 3'd2,
        KIND_TEMP      = 3'd3,
        KIND_DATE      = 3'd4
    } t_kind;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [3:0] slot_index;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  mem_address;
        logic [7:0]  mem_data;
        logic        pin_level;
        logic [39:0] date_value;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       step;
        logic       mark;
        logic       free;
        logic [3:0] free_idx;
    } t_slot_cmd;

    typedef struct packed {
        logic cur_used;
    } t_slot_sts;

    typedef struct packed {
        logic       wr;
        logic       clear;
        logic [7:0] data;
    } t_msg_cmd;

endpackage
`default_nettype wire

@@ sv/byte_command_mailbox_parser.sv @@
// Byte command and mailbox parser: sequencer, date capture and result register.
// A pin or temperature command or the last date byte gives its result in the output register in
// the cycle after accept. A commit ('!') checks one slot per cycle through the pointer unit;
// then MESSAGE_LENGTH write results, one per cycle while output is free; if full, one reject.
// Throughput: 1 request per cycle while output is free; a commit holds stall for its whole run.
// Reset (synchronous, active low): pointer 0, all slots free, buffer reads as spaces, capture off.
`timescale 1ns / 1ps
`default_nettype none
module byte_command_mailbox_parser import bcmp_pkg::*; #(
    parameter int SLOT_COUNT     = BCMP_SLOT_COUNT,
    parameter int MESSAGE_LENGTH = BCMP_MESSAGE_LENGTH,
    parameter int DATE_LENGTH    = BCMP_DATE_LENGTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int PW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW  = $clog2(SLOT_COUNT + 1);
    localparam int MIW = (MESSAGE_LENGTH > 1) ? $clog2(MESSAGE_LENGTH) : 1;
    localparam int DIW = (DATE_LENGTH > 1) ? $clog2(DATE_LENGTH) : 1;
    localparam int DOB = (DATE_LENGTH < DATE_VALUE_BYTES) ? DATE_LENGTH : DATE_VALUE_BYTES;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_WRITE  = 4'b0100,
        S_REJECT = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_chk, n_chk;
    logic [MIW-1:0] r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;
    t_out           r_out, n_out;
    logic [7:0]     r_date [DATE_LENGTH];
    logic [7:0]     n_date [DATE_LENGTH];
    logic [DIW-1:0] r_dfill, n_dfill;
    logic           r_armed, n_armed;

    t_slot_cmd      w_slot_cmd;
    t_slot_sts      w_slot_sts;
    logic [PW-1:0]  w_ptr;
    t_msg_cmd       w_msg_cmd;
    logic [7:0]     w_msg_data;
    logic [7:0]     w_base;
    logic [39:0]    w_date_val;
    logic           w_acc;
    logic           w_out_free;
    logic [7:0]     w_b;

    bcmp_slot_search #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_slot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_slot_cmd),
        .o_sts  (w_slot_sts),
        .o_ptr  (w_ptr)
    );

    bcmp_msg_buf #(
        .MESSAGE_LENGTH(MESSAGE_LENGTH)
    ) u_msg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_msg_cmd),
        .i_rd_idx (r_cnt),
        .o_rd_data(w_msg_data)
    );

    assign w_b        = i_data.rx_byte;
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_acc      = i_valid && !o_stall;
    assign w_base     = (8'(w_ptr) + 8'd1) << SLOT_STRIDE_SHIFT;

    always_comb begin
        w_date_val = '0;
        for (int i = 0; i < DOB; i++) begin
            w_date_val[8*i +: 8] = (DIW'(i) == r_dfill) ? w_b : r_date[i];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_chk       = r_chk;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        n_date      = r_date;
        n_dfill     = r_dfill;
        n_armed     = r_armed;
        w_slot_cmd  = '0;
        w_msg_cmd   = '0;
        w_msg_cmd.data = w_b;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_data.mode) begin
                        w_slot_cmd.free     = 1'b1;
                        w_slot_cmd.free_idx = i_data.slot_index;
                    end else if (w_b >= CMD_BASE) begin
                        case (w_b)
                            CMD_PIN_LOW: begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.kind  = KIND_PIN;
                                n_out.last  = 1'b1;
                            end
                            CMD_PIN_HIGH: begin
                                n_out_valid     = 1'b1;
                                n_out           = '0;
                                n_out.kind      = KIND_PIN;
                                n_out.pin_level = 1'b1;
                                n_out.last      = 1'b1;
                            end
                            CMD_TEMP: begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.kind  = KIND_TEMP;
                                n_out.last  = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end else if (w_b == CH_COMMIT) begin
                        n_state = S_SEARCH;
                        n_chk   = '0;
                    end else if (w_b == CH_DATE) begin
                        n_armed = 1'b1;
                    end else if (r_armed) begin
                        n_date[r_dfill] = w_b;
                        if (r_dfill == DIW'(DATE_LENGTH - 1)) begin
                            n_dfill          = '0;
                            n_armed          = 1'b0;
                            n_out_valid      = 1'b1;
                            n_out            = '0;
                            n_out.kind       = KIND_DATE;
                            n_out.date_value = w_date_val;
                            n_out.last       = 1'b1;
                        end else begin
                            n_dfill = r_dfill + 1'b1;
                        end
                    end else begin
                        w_msg_cmd.wr = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                if (!w_slot_sts.cur_used) begin
                    n_state = S_WRITE;
                    n_cnt   = '0;
                end else begin
                    w_slot_cmd.step = 1'b1;
                    if (r_chk == CW'(SLOT_COUNT)) begin
                        n_state = S_REJECT;
                    end else begin
                        n_chk = r_chk + 1'b1;
                    end
                end
            end
            S_WRITE: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.kind        = KIND_MEM_WRITE;
                    n_out.mem_address = w_base + 8'(r_cnt);
                    n_out.mem_data    = w_msg_data;
                    if (r_cnt == MIW'(MESSAGE_LENGTH - 1)) begin
                        n_out.last       = 1'b1;
                        w_slot_cmd.mark  = 1'b1;
                        w_msg_cmd.clear  = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_REJECT: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.kind      = KIND_REJECT;
                    n_out.last      = 1'b1;
                    w_msg_cmd.clear = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_dfill     <= '0;
            r_armed     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk       <= n_chk;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_dfill     <= n_dfill;
            r_armed     <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_date <= n_date;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> (r_state == S_IDLE))
        else $error("request accepted while sequencer busy");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && n_state == S_REJECT) |-> (r_chk == CW'(SLOT_COUNT)))
        else $error("reject before all slot checks were made");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> !w_slot_sts.cur_used)
        else $error("message burst targets a used slot");

    a_search_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_SEARCH) |=> (r_chk == '0))
        else $error("slot search started with stale check count");

endmodule
`default_nettype wire

@@ sv/bcmp_slot_search.sv @@
// Mailbox slot occupancy flags and slot pointer with a shared wrap-increment unit.
`timescale 1ns / 1ps
`default_nettype none
module bcmp_slot_search import bcmp_pkg::*; #(
    parameter int SLOT_COUNT = BCMP_SLOT_COUNT,
    localparam int PW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_slot_cmd             i_cmd,
    output t_slot_sts             o_sts,
    output logic [PW-1:0]         o_ptr
);

    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [PW-1:0]         r_ptr, n_ptr;
    logic [PW-1:0]         w_ptr_inc;

    assign w_ptr_inc = (r_ptr == PW'(SLOT_COUNT - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_used = r_used;
        n_ptr  = r_ptr;
        if (i_cmd.step) begin
            n_ptr = w_ptr_inc;
        end
        if (i_cmd.mark) begin
            n_used[r_ptr] = 1'b1;
            n_ptr         = w_ptr_inc;
        end
        if (i_cmd.free && ({28'd0, i_cmd.free_idx} < SLOT_COUNT)) begin
            n_used[i_cmd.free_idx[PW-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ptr  <= '0;
        end else begin
            r_used <= n_used;
            r_ptr  <= n_ptr;
        end
    end

    assign o_sts.cur_used = r_used[r_ptr];
    assign o_ptr          = r_ptr;

endmodule
`default_nettype wire

@@ sv/bcmp_msg_buf.sv @@
// Message buffer with per-byte valid flags; unwritten bytes read as spaces.
`timescale 1ns / 1ps
`default_nettype none
module bcmp_msg_buf import bcmp_pkg::*; #(
    parameter int MESSAGE_LENGTH = BCMP_MESSAGE_LENGTH,
    localparam int MIW = (MESSAGE_LENGTH > 1) ? $clog2(MESSAGE_LENGTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_msg_cmd       i_cmd,
    input  logic [MIW-1:0] i_rd_idx,
    output logic [7:0]     o_rd_data
);

    logic [7:0]              r_byte [MESSAGE_LENGTH];
    logic [MESSAGE_LENGTH-1:0] r_vld, n_vld;
    logic [MIW-1:0]          r_fill, n_fill;

    always_comb begin
        n_vld  = r_vld;
        n_fill = r_fill;
        if (i_cmd.wr) begin
            n_vld[r_fill] = 1'b1;
            n_fill = (r_fill == MIW'(MESSAGE_LENGTH - 1)) ? '0 : r_fill + 1'b1;
        end
        if (i_cmd.clear) begin
            n_vld  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_fill <= '0;
        end else begin
            r_vld  <= n_vld;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_byte[r_fill] <= i_cmd.data;
        end
    end

    assign o_rd_data = r_vld[i_rd_idx] ? r_byte[i_rd_idx] : CH_SPACE;

endmodule
`default_nettype wire

@@ sim/byte_command_mailbox_parser_checker.sv @@
// Request/result monitor for the mailbox parser: predicts each result and compares it.
`timescale 1ns / 1ps
module byte_command_mailbox_parser_checker
    import bcmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_in  i_req,
    input  logic i_res_valid,
    input  logic i_res_stall,
    input  t_out i_res,
    output int   o_fail_count,
    output int   o_owed_count,
    output int   o_checked_count,
    output int   o_reject_count
);

    logic [7:0] msg_buf [BCMP_MESSAGE_LENGTH];
    logic [7:0] date_buf [BCMP_DATE_LENGTH];
    logic       slot_busy [BCMP_SLOT_COUNT];
    int         msg_fill;
    int         date_fill;
    int         slot_ptr;
    logic       date_armed;
    t_out       owed_results [$];

    initial begin
        o_fail_count    = 0;
        o_owed_count    = 0;
        o_checked_count = 0;
        o_reject_count  = 0;
    end

    function automatic void clear_message();
        for (int i = 0; i < BCMP_MESSAGE_LENGTH; i++) begin
            msg_buf[i] = CH_SPACE;
        end
        msg_fill = 0;
    endfunction

    function automatic void owe(input t_kind k, input logic [7:0] addr,
                                input logic [7:0] data, input logic pin,
                                input logic [39:0] date, input logic fin);
        t_out r;
        r.kind        = k;
        r.mem_address = addr;
        r.mem_data    = data;
        r.pin_level   = pin;
        r.date_value  = date;
        r.last        = fin;
        owed_results.push_back(r);
    endfunction

    function automatic void commit_message();
        bit found;
        found = 1'b0;
        for (int n = 0; n <= BCMP_SLOT_COUNT && !found; n++) begin
            if (!slot_busy[slot_ptr]) begin
                found = 1'b1;
            end else begin
                slot_ptr = (slot_ptr + 1) % BCMP_SLOT_COUNT;
            end
        end
        if (found) begin
            for (int i = 0; i < BCMP_MESSAGE_LENGTH; i++) begin
                owe(KIND_MEM_WRITE, 8'(16 * (slot_ptr + 1) + i), msg_buf[i], 1'b0, 40'd0,
                    i == BCMP_MESSAGE_LENGTH - 1);
            end
            slot_busy[slot_ptr] = 1'b1;
            slot_ptr = (slot_ptr + 1) % BCMP_SLOT_COUNT;
        end else begin
            owe(KIND_REJECT, 8'd0, 8'd0, 1'b0, 40'd0, 1'b1);
        end
        clear_message();
    endfunction

    function automatic void parse_request(input t_in req);
        logic [7:0]  b;
        logic [39:0] dv;
        b = req.rx_byte;
        if (req.mode) begin
            if (req.slot_index < BCMP_SLOT_COUNT) begin
                slot_busy[req.slot_index] = 1'b0;
            end
        end else if (b >= CMD_BASE) begin
            if (b == CMD_PIN_LOW) begin
                owe(KIND_PIN, 8'd0, 8'd0, 1'b0, 40'd0, 1'b1);
            end else if (b == CMD_PIN_HIGH) begin
                owe(KIND_PIN, 8'd0, 8'd0, 1'b1, 40'd0, 1'b1);
            end else if (b == CMD_TEMP) begin
                owe(KIND_TEMP, 8'd0, 8'd0, 1'b0, 40'd0, 1'b1);
            end
        end else if (b == CH_COMMIT) begin
            commit_message();
        end else if (b == CH_DATE) begin
            date_armed = 1'b1;
        end else if (date_armed) begin
            date_buf[date_fill] = b;
            date_fill++;
            if (date_fill >= BCMP_DATE_LENGTH) begin
                dv = '0;
                for (int i = 0; i < BCMP_DATE_LENGTH && i < DATE_VALUE_BYTES; i++) begin
                    dv[8*i +: 8] = date_buf[i];
                end
                date_fill  = 0;
                date_armed = 1'b0;
                owe(KIND_DATE, 8'd0, 8'd0, 1'b0, dv, 1'b1);
            end
        end else begin
            msg_buf[msg_fill] = b;
            msg_fill = (msg_fill + 1) % BCMP_MESSAGE_LENGTH;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out  exp;
        string bad;
        if (!i_rst_n) begin
            clear_message();
            for (int i = 0; i < BCMP_SLOT_COUNT; i++) begin
                slot_busy[i] = 1'b0;
            end
            for (int i = 0; i < BCMP_DATE_LENGTH; i++) begin
                date_buf[i] = 8'd0;
            end
            slot_ptr   = 0;
            date_fill  = 0;
            date_armed = 1'b0;
            owed_results.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                parse_request(i_req);
            end
            if (i_res_valid && !i_res_stall) begin
                if (owed_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result kind=%0d addr=%h data=%h pin=%b date=%h last=%b",
                             $time, i_res.kind, i_res.mem_address, i_res.mem_data,
                             i_res.pin_level, i_res.date_value, i_res.last);
                end else begin
                    exp = owed_results.pop_front();
                    bad = "";
                    if (i_res.kind !== exp.kind) bad = {bad, " kind"};
                    if (i_res.mem_address !== exp.mem_address) bad = {bad, " mem_address"};
                    if (i_res.mem_data !== exp.mem_data) bad = {bad, " mem_data"};
                    if (i_res.pin_level !== exp.pin_level) bad = {bad, " pin_level"};
                    if (i_res.date_value !== exp.date_value) bad = {bad, " date_value"};
                    if (i_res.last !== exp.last) bad = {bad, " last"};
                    o_checked_count++;
                    if (exp.kind == KIND_REJECT) o_reject_count++;
                    if (bad != "") begin
                        o_fail_count++;
                        $display("%0t: mismatch in%s", $time, bad);
                        $display("    expected kind=%0d addr=%h data=%h pin=%b date=%h last=%b",
                                 exp.kind, exp.mem_address, exp.mem_data, exp.pin_level,
                                 exp.date_value, exp.last);
                        $display("    actual   kind=%0d addr=%h data=%h pin=%b date=%h last=%b",
                                 i_res.kind, i_res.mem_address, i_res.mem_data,
                                 i_res.pin_level, i_res.date_value, i_res.last);
                    end
                end
            end
        end
        o_owed_count = owed_results.size();
    end

endmodule

@@ sim/byte_command_mailbox_parser_tb.sv @@
// Testbench top for the mailbox parser: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module byte_command_mailbox_parser_tb;
    import bcmp_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    int fail_count;
    int owed_count;
    int checked_count;
    int reject_count;
    int sent_count   = 0;
    int commit_count = 0;
    int free_count   = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit rx_hold_req  = 1'b0;

    always #1 i_clk = ~i_clk;

    byte_command_mailbox_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    byte_command_mailbox_parser_checker watch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req           (i_data),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res           (o_data),
        .o_fail_count    (fail_count),
        .o_owed_count    (owed_count),
        .o_checked_count (checked_count),
        .o_reject_count  (reject_count)
    );

    initial begin
        #2_000_000;
        $display("run timed out");
        $display("byte_command_mailbox_parser regression: fail");
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !rx_steady && ($urandom_range(99) < 27);
            end
        end
    end

    task automatic send_request(input t_in req);
        int gap;
        gap = 0;
        if (!tx_steady) begin
            while (gap < 8 && $urandom_range(99) < 27) gap++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (req.mode) free_count++;
        else if (req.rx_byte == CH_COMMIT) commit_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in req;
        req.mode       = 1'b0;
        req.rx_byte    = b;
        req.slot_index = 4'($urandom_range(15));
        send_request(req);
    endtask

    task automatic free_slot(input logic [3:0] idx);
        t_in req;
        req.mode       = 1'b1;
        req.rx_byte    = 8'($urandom_range(255));
        req.slot_index = idx;
        send_request(req);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(199)); while (c == CH_COMMIT || c == CH_DATE);
        return c;
    endfunction

    function automatic t_in random_request();
        t_in req;
        int  pick;
        pick           = $urandom_range(99);
        req.mode       = 1'b0;
        req.rx_byte    = text_byte();
        req.slot_index = 4'($urandom_range(15));
        if (pick < 10) begin
            req.mode    = 1'b1;
            req.rx_byte = 8'($urandom_range(255));
        end else if (pick < 16) begin
            case ($urandom_range(2))
                0: req.rx_byte = CMD_PIN_LOW;
                1: req.rx_byte = CMD_PIN_HIGH;
                default: req.rx_byte = CMD_TEMP;
            endcase
        end else if (pick < 19) begin
            req.rx_byte = 8'($urandom_range(255, 200));
        end else if (pick < 29) begin
            req.rx_byte = CH_COMMIT;
        end else if (pick < 33) begin
            req.rx_byte = CH_DATE;
        end
        return req;
    endfunction

    initial begin : stimulus
        t_in req;
        int  useful;
        int  guard;
        bit  ignored;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(CMD_PIN_LOW);
        send_byte(CMD_PIN_HIGH);
        send_byte(CMD_TEMP);
        send_byte(CMD_BASE);
        send_byte(8'hFD);
        send_byte(8'h00);
        send_byte(8'hC7);
        send_byte(CH_COMMIT);
        send_byte(CH_DATE);
        send_byte(8'h00);
        send_byte(8'hC7);
        send_byte(CH_DATE);
        send_byte(8'h41);
        send_byte(CH_COMMIT);
        send_byte(8'h12);
        send_byte(8'h34);
        free_slot(4'd15);
        free_slot(4'd0);
        free_slot(4'd9);

        // fill the mailbox until it rejects, with the result side held off at first
        rx_hold_req = 1'b1;
        repeat (BCMP_SLOT_COUNT + 1) begin
            repeat ($urandom_range(3, 1)) send_byte(text_byte());
            send_byte(CH_COMMIT);
        end

        useful = 0;
        while (useful < 70) begin
            tx_steady = (useful >= 25 && useful < 50);
            rx_steady = tx_steady;
            req = random_request();
            ignored = req.mode ? (req.slot_index >= BCMP_SLOT_COUNT)
                               : (req.rx_byte >= CMD_BASE && req.rx_byte != CMD_PIN_LOW &&
                                  req.rx_byte != CMD_PIN_HIGH && req.rx_byte != CMD_TEMP);
            send_request(req);
            if (!ignored) useful++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        for (guard = 0; guard < 100000 && owed_count != 0; guard++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests: %0d commits, %0d slot frees, commands and date captures",
                 sent_count, commit_count, free_count);
        $display("checked %0d results, %0d of them mailbox-full rejects",
                 checked_count, reject_count);
        if (fail_count == 0 && owed_count == 0) begin
            $display("byte_command_mailbox_parser regression: pass");
        end else begin
            if (owed_count != 0) $display("%0d expected results never arrived", owed_count);
            $display("byte_command_mailbox_parser regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bcmp_pkg.sv
sv/bcmp_slot_search.sv
sv/bcmp_msg_buf.sv
sv/byte_command_mailbox_parser.sv
sim/byte_command_mailbox_parser_checker.sv
sim/byte_command_mailbox_parser_tb.sv
